/* hdl/ssde_pkg.sv */
// ----------------------------------------------------------------------------
// ssde_pkg
// Shared types and constants for the sprite and sample DMA engine.
// ----------------------------------------------------------------------------
package ssde_pkg;

    // Default sprite transfer length in bytes
    localparam int unsigned SPRITE_BYTES_DEF = 256;

    // Sprite data port address
    localparam logic [15:0] OAM_PORT = 16'h2004;

    // Sample fetch: three dummy reads, then the sample read
    localparam int unsigned SAMPLE_STEPS = 4;
    localparam int unsigned SAMPLE_PH_W  = $clog2(SAMPLE_STEPS);

    // Sprite sequencer phase codes
    localparam logic [1:0] SPR_PH_DUMMY = 2'd0;
    localparam logic [1:0] SPR_PH_ALIGN = 2'd1;
    localparam logic [1:0] SPR_PH_READ  = 2'd2;
    localparam logic [1:0] SPR_PH_WRITE = 2'd3;

    // One bus cycle item
    typedef struct packed {
        logic        bus_grant;
        logic        oam_request;
        logic [7:0]  oam_page;
        logic        dmc_request;
        logic [15:0] dmc_address;
        logic        odd_cycle;
        logic [15:0] cpu_pc;
        logic [7:0]  read_data;
    } item_t;

    // One result item
    typedef struct packed {
        logic        bus_valid;
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic        sample_valid;
        logic [7:0]  sample_byte;
        logic        oam_done;
        logic        dma_busy;
    } result_t;

endpackage

/* hdl/ssde_in_stage.sv */
// ----------------------------------------------------------------------------
// ssde_in_stage
// Input register: holds one bus cycle item until the core takes it.
// ----------------------------------------------------------------------------
module ssde_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cycle_valid,
    output logic            cycle_stall,
    input  ssde_pkg::item_t cycle_item,
    input  logic            advance,
    output logic            item_valid,
    output ssde_pkg::item_t item
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    ssde_pkg::item_t hold_item_reg;
    logic            load;

    // Take a new item when empty or when the held one moves on
    assign load        = !hold_valid_reg || advance;
    assign cycle_stall = !load;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (load)
        begin
            hold_valid_next = cycle_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load && cycle_valid)
        begin
            hold_item_reg <= cycle_item;
        end
    end

    assign item_valid = hold_valid_reg;
    assign item       = hold_item_reg;

endmodule

/* hdl/ssde_core.sv */
// ----------------------------------------------------------------------------
// ssde_core
// Transfer state and the combinational step logic for one bus cycle item.
// ----------------------------------------------------------------------------
module ssde_core
#(
    parameter int unsigned SPRITE_BYTES = ssde_pkg::SPRITE_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ssde_pkg::item_t   item,
    output ssde_pkg::result_t result
);

    localparam int unsigned IDX_W = $clog2(SPRITE_BYTES + 1);
    localparam int unsigned SPW   = ssde_pkg::SAMPLE_PH_W;

    logic             sprite_pending_reg, sprite_pending_next;
    logic [7:0]       sprite_page_reg, sprite_page_next;
    logic             sprite_active_reg, sprite_active_next;
    logic [1:0]       sprite_phase_reg, sprite_phase_next;
    logic             align_needed_reg, align_needed_next;
    logic [IDX_W-1:0] sprite_index_reg, sprite_index_next;
    logic             sample_pending_reg, sample_pending_next;
    logic [15:0]      sample_addr_reg, sample_addr_next;
    logic             sample_active_reg, sample_active_next;
    logic [SPW-1:0]   sample_phase_reg, sample_phase_next;
    logic             sample_collect_reg, sample_collect_next;
    logic [7:0]       data_latch_reg, data_latch_next;
    logic             latch_due_reg, latch_due_next;

    logic             idle_bus;
    logic             start_sample;
    logic             start_sprite;
    logic [IDX_W-1:0] idx_inc;
    logic [8:0]       idx_ext;

    // Step logic for one item
    always_comb
    begin
        sprite_pending_next = sprite_pending_reg;
        sprite_page_next    = sprite_page_reg;
        sprite_active_next  = sprite_active_reg;
        sprite_phase_next   = sprite_phase_reg;
        align_needed_next   = align_needed_reg;
        sprite_index_next   = sprite_index_reg;
        sample_pending_next = sample_pending_reg;
        sample_addr_next    = sample_addr_reg;
        sample_active_next  = sample_active_reg;
        sample_phase_next   = sample_phase_reg;
        sample_collect_next = 1'b0;
        data_latch_next     = latch_due_reg ? item.read_data : data_latch_reg;
        latch_due_next      = 1'b0;
        idx_inc             = sprite_index_reg + IDX_W'(1);
        idx_ext             = 9'(sprite_index_reg);
        result              = '0;

        // Hand out a sample byte fetched on the previous item
        result.sample_valid = sample_collect_reg;
        result.sample_byte  = sample_collect_reg ? item.read_data : 8'h00;

        // Take new requests unless one of the same kind is in flight
        if (item.oam_request && !sprite_pending_reg && !sprite_active_reg)
        begin
            sprite_pending_next = 1'b1;
            sprite_page_next    = item.oam_page;
        end
        if (item.dmc_request && !sample_pending_reg && !sample_active_reg)
        begin
            sample_pending_next = 1'b1;
            sample_addr_next    = item.dmc_address;
        end

        // Start a transfer; sample wins
        idle_bus     = item.bus_grant && !sample_active_reg && !sprite_active_reg;
        start_sample = idle_bus && sample_pending_next;
        start_sprite = idle_bus && !sample_pending_next && sprite_pending_next;
        if (start_sample)
        begin
            sample_pending_next = 1'b0;
            sample_active_next  = 1'b1;
            sample_phase_next   = '0;
        end
        if (start_sprite)
        begin
            sprite_pending_next = 1'b0;
            sprite_active_next  = 1'b1;
            align_needed_next   = item.odd_cycle;
            sprite_phase_next   = ssde_pkg::SPR_PH_DUMMY;
            sprite_index_next   = '0;
            idx_inc             = IDX_W'(1);
            idx_ext             = 9'd0;
        end

        // Drive the bus access
        if (item.bus_grant && sample_active_next)
        begin
            result.bus_valid = 1'b1;
            if (sample_phase_next == SPW'(ssde_pkg::SAMPLE_STEPS - 1))
            begin
                result.bus_address  = sample_addr_next;
                sample_active_next  = 1'b0;
                sample_phase_next   = '0;
                sample_collect_next = 1'b1;
            end
            else
            begin
                result.bus_address = item.cpu_pc;
                sample_phase_next  = sample_phase_next + SPW'(1);
            end
        end
        else if (item.bus_grant && sprite_active_next)
        begin
            result.bus_valid = 1'b1;
            case (sprite_phase_next)
                ssde_pkg::SPR_PH_DUMMY:
                begin
                    result.bus_address = item.cpu_pc;
                    sprite_phase_next  = align_needed_next ? ssde_pkg::SPR_PH_ALIGN
                                                           : ssde_pkg::SPR_PH_READ;
                end
                ssde_pkg::SPR_PH_ALIGN:
                begin
                    result.bus_address = item.cpu_pc;
                    align_needed_next  = 1'b0;
                    sprite_phase_next  = ssde_pkg::SPR_PH_READ;
                end
                ssde_pkg::SPR_PH_READ:
                begin
                    result.bus_address = {sprite_page_next, idx_ext[7:0]};
                    latch_due_next     = 1'b1;
                    sprite_phase_next  = ssde_pkg::SPR_PH_WRITE;
                end
                default:
                begin
                    result.bus_write   = 1'b1;
                    result.bus_address = ssde_pkg::OAM_PORT;
                    result.bus_data    = data_latch_next;
                    sprite_index_next  = idx_inc;
                    if (idx_inc == IDX_W'(SPRITE_BYTES))
                    begin
                        sprite_active_next = 1'b0;
                        sprite_phase_next  = ssde_pkg::SPR_PH_DUMMY;
                        result.oam_done    = 1'b1;
                    end
                    else
                    begin
                        sprite_phase_next = ssde_pkg::SPR_PH_READ;
                    end
                end
            endcase
        end

        result.dma_busy = result.bus_valid || sprite_pending_next || sprite_active_next ||
                          sample_pending_next || sample_active_next || sample_collect_next;
    end

    // Advance the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_pending_reg <= 1'b0;
            sprite_active_reg  <= 1'b0;
            sprite_phase_reg   <= ssde_pkg::SPR_PH_DUMMY;
            align_needed_reg   <= 1'b0;
            sprite_index_reg   <= '0;
            sample_pending_reg <= 1'b0;
            sample_active_reg  <= 1'b0;
            sample_phase_reg   <= '0;
            sample_collect_reg <= 1'b0;
            latch_due_reg      <= 1'b0;
        end
        else if (advance)
        begin
            sprite_pending_reg <= sprite_pending_next;
            sprite_active_reg  <= sprite_active_next;
            sprite_phase_reg   <= sprite_phase_next;
            align_needed_reg   <= align_needed_next;
            sprite_index_reg   <= sprite_index_next;
            sample_pending_reg <= sample_pending_next;
            sample_active_reg  <= sample_active_next;
            sample_phase_reg   <= sample_phase_next;
            sample_collect_reg <= sample_collect_next;
            latch_due_reg      <= latch_due_next;
        end
    end

    // Advance page, address and data latch
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sprite_page_reg <= sprite_page_next;
            sample_addr_reg <= sample_addr_next;
            data_latch_reg  <= data_latch_next;
        end
    end

    // Only one transfer owns the bus at a time
    a_one_active: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_active_reg && sprite_active_reg))
        else $error("sample and sprite transfers active together");

    // A byte awaited for audio means the sample transfer has finished
    a_collect_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_collect_reg |-> !sample_active_reg)
        else $error("sample byte awaited while sample fetch still active");

    // A latched sprite byte is always followed by its write phase
    a_latch_write: assert property (@(posedge clk) disable iff (!rst_n)
        latch_due_reg |-> (sprite_active_reg && sprite_phase_reg == ssde_pkg::SPR_PH_WRITE))
        else $error("sprite byte latched outside the write phase");

    // Byte index stays inside the page transfer
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sprite_active_reg |-> (sprite_index_reg <= IDX_W'(SPRITE_BYTES - 1)))
        else $error("sprite index past the transfer length");

    // A held item leaves the state untouched
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(sprite_index_reg) && $stable(sample_phase_reg)))
        else $error("transfer state moved without an item");

endmodule

/* hdl/ssde_out_stage.sv */
// ----------------------------------------------------------------------------
// ssde_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module ssde_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ssde_pkg::result_t result,
    output logic              room,
    output logic              access_valid,
    input  logic              access_stall,
    output ssde_pkg::result_t access
);

    logic              res_valid_reg;
    logic              res_valid_next;
    ssde_pkg::result_t res_reg;

    // Accept a result when empty or when the current one leaves
    assign room = !res_valid_reg || !access_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg && access_stall;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign access_valid = res_valid_reg;
    assign access       = res_reg;

endmodule

/* hdl/sprite_and_sample_dma_engine_unit.sv */
// ----------------------------------------------------------------------------
// sprite_and_sample_dma_engine_unit
// Sprite page copy and sample byte fetch DMA, one bus cycle per item.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  cycle     cycle_valid / cycle_stall    bus_grant .. read_data (one bus cycle)
//  access    access_valid / access_stall  bus_valid .. dma_busy (one result)
//
//  One item per clock sustained while access_stall is low; an accepted item waits in the input
//  register, then the step logic between the two registers computes its result, which is
//  captured in the result register and taken from there by the consumer.
//  Reset clears the transfer control state; no transfer is pending after reset.
//  A stall on access backs up into cycle_stall only once both registers hold.
// ----------------------------------------------------------------------------
module sprite_and_sample_dma_engine_unit
#(
    parameter int unsigned SPRITE_BYTES = ssde_pkg::SPRITE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cycle_valid,
    output logic        cycle_stall,
    input  logic        bus_grant,
    input  logic        oam_request,
    input  logic [7:0]  oam_page,
    input  logic        dmc_request,
    input  logic [15:0] dmc_address,
    input  logic        odd_cycle,
    input  logic [15:0] cpu_pc,
    input  logic [7:0]  read_data,
    output logic        access_valid,
    input  logic        access_stall,
    output logic        bus_valid,
    output logic        bus_write,
    output logic [15:0] bus_address,
    output logic [7:0]  bus_data,
    output logic        sample_valid,
    output logic [7:0]  sample_byte,
    output logic        oam_done,
    output logic        dma_busy
);

    ssde_pkg::item_t   cycle_item;
    ssde_pkg::item_t   item;
    ssde_pkg::result_t result;
    ssde_pkg::result_t access;
    logic              item_valid;
    logic              room;
    logic              advance;

    // Pack the input fields
    always_comb
    begin
        cycle_item.bus_grant   = bus_grant;
        cycle_item.oam_request = oam_request;
        cycle_item.oam_page    = oam_page;
        cycle_item.dmc_request = dmc_request;
        cycle_item.dmc_address = dmc_address;
        cycle_item.odd_cycle   = odd_cycle;
        cycle_item.cpu_pc      = cpu_pc;
        cycle_item.read_data   = read_data;
    end

    // Move an item through the step logic when the result register has room
    assign advance = item_valid && room;

    ssde_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cycle_valid (cycle_valid),
        .cycle_stall (cycle_stall),
        .cycle_item  (cycle_item),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    ssde_core
    #(
        .SPRITE_BYTES (SPRITE_BYTES)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ssde_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .result       (result),
        .room         (room),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .access       (access)
    );

    // Unpack the result fields
    assign bus_valid    = access.bus_valid;
    assign bus_write    = access.bus_write;
    assign bus_address  = access.bus_address;
    assign bus_data     = access.bus_data;
    assign sample_valid = access.sample_valid;
    assign sample_byte  = access.sample_byte;
    assign oam_done     = access.oam_done;
    assign dma_busy     = access.dma_busy;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sprite and sample DMA engine. Each cycle item that is sent
// is run through a cycle-accurate software copy of the engine, and the access
// it should produce is queued. Every access the engine hands out is checked
// field by field against the oldest queued one. Directed items cover the
// corner cases. Random traffic follows in several phases of sender idling
// and receiver stalls, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SPRITE_LEN = ssde_pkg::SPRITE_BYTES_DEF;
    localparam int unsigned RANDOM_ITEMS = 230;
    localparam int unsigned REPORT_LIMIT = 10;

    logic        clk;
    logic        rst_n;
    logic        cycle_valid;
    logic        cycle_stall;
    logic        bus_grant;
    logic        oam_request;
    logic [7:0]  oam_page;
    logic        dmc_request;
    logic [15:0] dmc_address;
    logic        odd_cycle;
    logic [15:0] cpu_pc;
    logic [7:0]  read_data;
    logic        access_valid;
    logic        access_stall;
    logic        bus_valid;
    logic        bus_write;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        oam_done;
    logic        dma_busy;

    // Engine state as seen by the predictor
    logic        spr_pending = 1'b0;
    logic [7:0]  spr_page = '0;
    logic        spr_active = 1'b0;
    logic [1:0]  spr_phase = ssde_pkg::SPR_PH_DUMMY;
    logic        align_due = 1'b0;
    logic [8:0]  spr_index = '0;
    logic        smp_pending = 1'b0;
    logic [15:0] smp_addr = '0;
    logic        smp_active = 1'b0;
    logic [2:0]  smp_phase = '0;
    logic        smp_collect = 1'b0;
    logic [7:0]  byte_latch = '0;
    logic        latch_due = 1'b0;

    // Accesses still owed by the engine, oldest first
    ssde_pkg::result_t access_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned mismatch_count = 0;

    sprite_and_sample_dma_engine_unit #(
        .SPRITE_BYTES (SPRITE_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cycle_valid  (cycle_valid),
        .cycle_stall  (cycle_stall),
        .bus_grant    (bus_grant),
        .oam_request  (oam_request),
        .oam_page     (oam_page),
        .dmc_request  (dmc_request),
        .dmc_address  (dmc_address),
        .odd_cycle    (odd_cycle),
        .cpu_pc       (cpu_pc),
        .read_data    (read_data),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .bus_valid    (bus_valid),
        .bus_write    (bus_write),
        .bus_address  (bus_address),
        .bus_data     (bus_data),
        .sample_valid (sample_valid),
        .sample_byte  (sample_byte),
        .oam_done     (oam_done),
        .dma_busy     (dma_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Advance the engine copy by one bus cycle and return the access it drives
    task automatic predict_access(input ssde_pkg::item_t c, output ssde_pkg::result_t r);
        r = '0;
        if (latch_due)
        begin
            byte_latch = c.read_data;
            latch_due  = 1'b0;
        end
        if (smp_collect)
        begin
            r.sample_valid = 1'b1;
            r.sample_byte  = c.read_data;
            smp_collect    = 1'b0;
        end
        // Take new requests; drop repeats while one of the same kind is open
        if (c.oam_request && !spr_pending && !spr_active)
        begin
            spr_pending = 1'b1;
            spr_page    = c.oam_page;
        end
        if (c.dmc_request && !smp_pending && !smp_active)
        begin
            smp_pending = 1'b1;
            smp_addr    = c.dmc_address;
        end
        if (c.bus_grant)
        begin
            // Start a transfer when the bus is free; the sample fetch wins
            if (!smp_active && !spr_active)
            begin
                if (smp_pending)
                begin
                    smp_pending = 1'b0;
                    smp_active  = 1'b1;
                    smp_phase   = '0;
                end
                else if (spr_pending)
                begin
                    spr_pending = 1'b0;
                    spr_active  = 1'b1;
                    align_due   = c.odd_cycle;
                    spr_phase   = ssde_pkg::SPR_PH_DUMMY;
                    spr_index   = '0;
                end
            end
            if (smp_active)
            begin
                r.bus_valid   = 1'b1;
                r.bus_address = (smp_phase < ssde_pkg::SAMPLE_STEPS - 1) ? c.cpu_pc
                                                                         : smp_addr;
                smp_phase     = smp_phase + 3'd1;
                if (smp_phase >= ssde_pkg::SAMPLE_STEPS)
                begin
                    smp_active  = 1'b0;
                    smp_phase   = '0;
                    smp_collect = 1'b1;
                end
            end
            else if (spr_active)
            begin
                r.bus_valid = 1'b1;
                case (spr_phase)
                    ssde_pkg::SPR_PH_DUMMY:
                    begin
                        r.bus_address = c.cpu_pc;
                        spr_phase     = align_due ? ssde_pkg::SPR_PH_ALIGN
                                                  : ssde_pkg::SPR_PH_READ;
                    end
                    ssde_pkg::SPR_PH_ALIGN:
                    begin
                        r.bus_address = c.cpu_pc;
                        align_due     = 1'b0;
                        spr_phase     = ssde_pkg::SPR_PH_READ;
                    end
                    ssde_pkg::SPR_PH_READ:
                    begin
                        r.bus_address = {spr_page, spr_index[7:0]};
                        latch_due     = 1'b1;
                        spr_phase     = ssde_pkg::SPR_PH_WRITE;
                    end
                    default:
                    begin
                        r.bus_write   = 1'b1;
                        r.bus_address = ssde_pkg::OAM_PORT;
                        r.bus_data    = byte_latch;
                        spr_index     = spr_index + 9'd1;
                        if (spr_index >= SPRITE_LEN)
                        begin
                            spr_active = 1'b0;
                            spr_phase  = ssde_pkg::SPR_PH_DUMMY;
                            r.oam_done = 1'b1;
                        end
                        else
                        begin
                            spr_phase = ssde_pkg::SPR_PH_READ;
                        end
                    end
                endcase
            end
        end
        r.dma_busy = r.bus_valid | spr_pending | spr_active | smp_pending |
                     smp_active | smp_collect;
    endtask

    function automatic ssde_pkg::item_t make_cycle(input logic grant, input logic oreq,
                                                   input logic [7:0] page, input logic dreq,
                                                   input logic [15:0] addr, input logic odd,
                                                   input logic [15:0] pc,
                                                   input logic [7:0] rd);
        ssde_pkg::item_t c;
        c.bus_grant   = grant;
        c.oam_request = oreq;
        c.oam_page    = page;
        c.dmc_request = dreq;
        c.dmc_address = addr;
        c.odd_cycle   = odd;
        c.cpu_pc      = pc;
        c.read_data   = rd;
        return c;
    endfunction

    function automatic ssde_pkg::item_t random_cycle();
        ssde_pkg::item_t c;
        c.bus_grant   = ($urandom_range(99) < 85);
        c.oam_request = ($urandom_range(99) < 3);
        c.oam_page    = 8'($urandom_range(255));
        c.dmc_request = ($urandom_range(99) < 6);
        c.dmc_address = 16'($urandom_range(65535));
        c.odd_cycle   = 1'($urandom_range(1));
        c.cpu_pc      = 16'($urandom_range(65535));
        c.read_data   = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic bit access_matches(input ssde_pkg::result_t a,
                                          input ssde_pkg::result_t b);
        return a.bus_valid === b.bus_valid && a.bus_write === b.bus_write &&
               a.bus_address === b.bus_address && a.bus_data === b.bus_data &&
               a.sample_valid === b.sample_valid && a.sample_byte === b.sample_byte &&
               a.oam_done === b.oam_done && a.dma_busy === b.dma_busy;
    endfunction

    // Send one cycle item; called and returns at a falling edge
    task automatic send_cycle(input ssde_pkg::item_t c);
        ssde_pkg::result_t r;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cycle_valid <= 1'b0;
            @(negedge clk);
        end
        cycle_valid <= 1'b1;
        bus_grant   <= c.bus_grant;
        oam_request <= c.oam_request;
        oam_page    <= c.oam_page;
        dmc_request <= c.dmc_request;
        dmc_address <= c.dmc_address;
        odd_cycle   <= c.odd_cycle;
        cpu_pc      <= c.cpu_pc;
        read_data   <= c.read_data;
        @(posedge clk);
        while (cycle_stall)
            @(posedge clk);
        predict_access(c, r);
        access_q.push_back(r);
        @(negedge clk);
    endtask

    // Hold the sender until every owed access has come out
    task automatic wait_drained();
        cycle_valid <= 1'b0;
        @(negedge clk);
        while (access_q.size() != 0)
            @(negedge clk);
    endtask

    // Idle cycles and field extremes with no request open
    task automatic test_reset_idle();
        send_cycle(make_cycle(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'hFF, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF));
    endtask

    // Sample fetch started on the request item, held once, byte handed out ungranted
    task automatic test_sample_fetch();
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 8'h00));
        send_cycle(make_cycle(1'b0, 1'b0, 8'h00, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 8'h11));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'hFFFF, 8'h22));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, 16'hFFFF, 8'h33));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 8'h44));
        send_cycle(make_cycle(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 8'hFF));
    endtask

    // Sample wins over sprite, repeats dropped, odd start, latch across a held cycle
    task automatic test_request_order();
        send_cycle(make_cycle(1'b0, 1'b1, 8'hFF, 1'b1, 16'h0000, 1'b0, 16'h1234, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b1, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h8001, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b1, 16'h7FFE, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h4242, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'hC0DE, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, 16'hA000, 8'h5A));
        send_cycle(make_cycle(1'b0, 1'b0, 8'h00, 1'b1, 16'hBEEF, 1'b0, 16'hA001, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'hA002, 8'h00));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, 16'hA003, 8'h00));
        send_cycle(make_cycle(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'hA004, 8'h3C));
        send_cycle(make_cycle(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'hA005, 8'h00));
    endtask

    // Long receiver hold-off while the sender keeps offering items
    task automatic test_output_backpressure();
        int unsigned n;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 300;
        for (n = 0; n < 60; n++)
            send_cycle(random_cycle());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall);
        int unsigned n;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_cycle(random_cycle());
    endtask

    // Drive the receiver stall: a requested hold-off first, else random
    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        access_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                access_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                access_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Check each accepted access against the oldest owed one
    always @(posedge clk)
    begin
        ssde_pkg::result_t want;
        ssde_pkg::result_t got;
        if (rst_n && access_valid && !access_stall)
        begin
            got = {bus_valid, bus_write, bus_address, bus_data,
                   sample_valid, sample_byte, oam_done, dma_busy};
            if (access_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: access with none owed: addr=%h wr=%0b", $realtime,
                             got.bus_address, got.bus_write);
            end
            else
            begin
                want = access_q.pop_front();
                if (!access_matches(want, got))
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: access mismatch exp v=%0b w=%0b a=%h d=%h ",
                                  "s=%0b/%h done=%0b busy=%0b got v=%0b w=%0b a=%h d=%h ",
                                  "s=%0b/%h done=%0b busy=%0b"}, $realtime,
                                 want.bus_valid, want.bus_write, want.bus_address,
                                 want.bus_data, want.sample_valid, want.sample_byte,
                                 want.oam_done, want.dma_busy,
                                 got.bus_valid, got.bus_write, got.bus_address,
                                 got.bus_data, got.sample_valid, got.sample_byte,
                                 got.oam_done, got.dma_busy);
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cycle_valid = 1'b0;
        bus_grant   = 1'b0;
        oam_request = 1'b0;
        oam_page    = '0;
        dmc_request = 1'b0;
        dmc_address = '0;
        odd_cycle   = 1'b0;
        cpu_pc      = '0;
        read_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_idle();
        test_sample_fetch();
        test_request_order();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(87, 0);
        test_random_traffic(0, 87);
        test_random_traffic(29, 29);

        // Let the engine drain, then give it time for anything stray
        stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && access_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* files.f */
hdl/ssde_pkg.sv
hdl/ssde_in_stage.sv
hdl/ssde_core.sv
hdl/ssde_out_stage.sv
hdl/sprite_and_sample_dma_engine_unit.sv
dv/tb_top.sv
